FILE: rtl/core/mtcp_pkg.sv
// Package for the MIDI track chunk parser: payload structs, result kinds, constants.
// No dependencies.
package mtcp_pkg;

    localparam int TickBitsDef = 40;
    localparam int VlqMaxDef   = 4;

    typedef enum logic [2:0] {
        K_CHAN = 3'd0,
        K_META = 3'd1,
        K_MDATA = 3'd2,
        K_DONE = 3'd3,
        K_ERR  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_track;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [39:0] abs_tick;
        logic [3:0]  msg_type;
        logic [3:0]  channel;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [1:0]  data_count;
        logic [7:0]  meta_type;
        logic [27:0] meta_len;
        logic        meta_fits;
        logic        last;
    } t_out;

    // Up to two results per byte travel together through the queue.
    typedef struct packed {
        t_out r0;
        t_out r1;
        logic two;
    } t_pair;

endpackage

FILE: rtl/core/midi_track_chunk_parser.sv
// MIDI track chunk parser top level. One byte accepted per cycle while o_stall
// is low; results go through a pair register and a two-deep pair queue and leave
// one per cycle while i_stall is low. A byte giving two results sends r0, then r1.
// Synchronous active-low reset returns the parser to expecting the tag.
// Depends on mtcp_pkg, mtcp_front, mtcp_back.
module midi_track_chunk_parser import mtcp_pkg::*; #(
    parameter int TICK_BITS     = TickBitsDef,
    parameter int VLQ_MAX_BYTES = VlqMaxDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic  pvalid, pstall;
    t_pair pair;

    mtcp_front #(.TICK_BITS(TICK_BITS), .VLQ_MAX_BYTES(VLQ_MAX_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_item(i_data), .o_stall,
        .o_pvalid(pvalid), .o_pair(pair), .i_pstall(pstall)
    );

    mtcp_back u_back (
        .i_clk, .i_rst_n, .i_pvalid(pvalid), .i_pair(pair), .o_pstall(pstall),
        .o_valid, .o_res(o_data), .i_stall
    );

    a_err_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == K_ERR |-> o_data.abs_tick == 40'd0)
        else $error("error result with nonzero tick");
    a_pair_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pvalid && pair.two |-> !pair.r0.last && pair.r1.last)
        else $error("pair last flags wrong");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pvalid && !pair.two |-> pair.r0.last)
        else $error("single result without last");

endmodule

FILE: rtl/core/mtcp_front.sv
// Front part: accepts bytes, runs the chunk parse state machine, forms result pairs.
// Depends on mtcp_pkg.
module mtcp_front import mtcp_pkg::*; #(
    parameter int TICK_BITS     = TickBitsDef,
    parameter int VLQ_MAX_BYTES = VlqMaxDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_item,
    output logic  o_stall,
    output logic  o_pvalid,
    output t_pair o_pair,
    input  logic  i_pstall
);

    typedef enum logic [12:0] {
        PH_TAG   = 13'h0001, PH_LEN   = 13'h0002, PH_DELTA = 13'h0004,
        PH_STAT  = 13'h0008, PH_MTYPE = 13'h0010, PH_MLEN  = 13'h0020,
        PH_MDATA = 13'h0040, PH_SKIP  = 13'h0080, PH_SXLEN = 13'h0100,
        PH_CH1   = 13'h0200, PH_CH2   = 13'h0400, PH_DONE  = 13'h0800,
        PH_ERR   = 13'h1000
    } t_phase;

    t_phase             r_ph, n_ph, ph0;
    logic [1:0]         r_tag, n_tag, tag0;
    logic [31:0]        r_left, n_left, left0;
    logic [TICK_BITS-1:0] r_tick, n_tick, tick0;
    logic [27:0]        r_acc, n_acc, acc0, acc_nx;
    logic [1:0]         r_vb, n_vb, vb0;
    logic [7:0]         r_rs, n_rs, rs0;
    logic [7:0]         r_d1, n_d1, d10;
    logic [1:0]         r_hc, n_hc, hc0;
    logic [7:0]         r_mt, n_mt, mt0;
    logic [27:0]        r_skip, n_skip, skip0;
    logic               vlq_end, one_d;
    t_out               res [2];
    logic [1:0]         cnt;
    logic [7:0]         b, tagc;
    logic [39:0]        tick_o, tick_n40;
    logic               acc;

    assign o_stall = o_pvalid & i_pstall;
    assign acc     = i_valid & ~o_stall;
    assign b       = i_item.data_byte;

    always_comb begin
        logic [2:0] k;
        logic [7:0] d1, d2;
        logic [1:0] dc;
        logic [27:0] ml;
        logic       mf, emit_ch, emit_mh;
        logic [7:0] mty;
        k = K_CHAN; d1 = '0; d2 = '0; dc = '0; ml = '0; mf = 1'b0; mty = '0;
        emit_ch = 1'b0; emit_mh = 1'b0;
        ph0 = i_item.start_track ? PH_TAG : r_ph;
        tag0  = i_item.start_track ? 2'd0 : r_tag;
        left0 = i_item.start_track ? 32'd0 : r_left;
        tick0 = i_item.start_track ? '0 : r_tick;
        acc0  = i_item.start_track ? 28'd0 : r_acc;
        vb0   = i_item.start_track ? 2'd0 : r_vb;
        rs0   = i_item.start_track ? 8'd0 : r_rs;
        d10   = i_item.start_track ? 8'd0 : r_d1;
        hc0   = i_item.start_track ? 2'd0 : r_hc;
        mt0   = i_item.start_track ? 8'd0 : r_mt;
        skip0 = i_item.start_track ? 28'd0 : r_skip;
        n_ph = ph0; n_tag = tag0; n_left = left0; n_tick = tick0; n_acc = acc0;
        n_vb = vb0; n_rs = rs0; n_d1 = d10; n_hc = hc0; n_mt = mt0; n_skip = skip0;
        cnt = 2'd0;
        res[0] = '0; res[1] = '0;
        unique case (tag0)
            2'd0: tagc = 8'h4D;
            2'd1: tagc = 8'h54;
            2'd2: tagc = 8'h72;
            default: tagc = 8'h6B;
        endcase
        acc_nx  = {acc0[20:0], b[6:0]};
        vlq_end = ~b[7] | ({1'b0, vb0} + 3'd1 >= 3'(VLQ_MAX_BYTES));
        one_d   = (rs0[7:4] == 4'hC) | (rs0[7:4] == 4'hD);
        tick_n40 = 40'(tick0);
        unique case (ph0)
            PH_TAG: begin
                if (b != tagc) begin
                    n_ph = PH_ERR; cnt = 2'd1; res[0].kind = K_ERR;
                end else if (tag0 == 2'd3) begin
                    n_tag = 2'd0; n_ph = PH_LEN;
                end else n_tag = tag0 + 2'd1;
            end
            PH_LEN: begin
                n_left = {left0[23:0], b};
                if (tag0 == 2'd3) begin
                    n_tag = 2'd0;
                    if (n_left == 32'd0) n_ph = PH_DONE;
                    else begin n_ph = PH_DELTA; n_acc = '0; n_vb = '0; end
                end else n_tag = tag0 + 2'd1;
            end
            PH_DONE, PH_ERR: ;
            default: begin
                n_left = left0 - 32'd1;
                unique case (ph0)
                    PH_DELTA: begin
                        n_acc = acc_nx;
                        if (vlq_end) begin
                            n_tick = tick0 + TICK_BITS'(acc_nx);
                            n_ph = PH_STAT;
                        end else n_vb = vb0 + 2'd1;
                    end
                    PH_STAT: begin
                        if (b == 8'hFF) n_ph = PH_MTYPE;
                        else if (b == 8'hF0 || b == 8'hF7) begin
                            n_ph = PH_SXLEN; n_acc = '0; n_vb = '0;
                        end else if (b[7]) begin
                            n_rs = b; n_hc = 2'd0; n_d1 = 8'd0; n_ph = PH_CH1;
                        end else if (rs0 == 8'd0) begin
                            n_ph = PH_DELTA; n_acc = '0; n_vb = '0;
                        end else begin
                            n_d1 = b; n_hc = 2'd1;
                            if (one_d) begin
                                emit_ch = 1'b1; n_ph = PH_DELTA; n_acc = '0; n_vb = '0;
                            end else n_ph = PH_CH2;
                        end
                    end
                    PH_CH1: begin
                        n_d1 = b; n_hc = 2'd1;
                        if (one_d) begin
                            emit_ch = 1'b1; n_ph = PH_DELTA; n_acc = '0; n_vb = '0;
                        end else n_ph = PH_CH2;
                    end
                    PH_CH2: begin
                        n_hc = 2'd2; emit_ch = 1'b1;
                        n_ph = PH_DELTA; n_acc = '0; n_vb = '0;
                    end
                    PH_MTYPE: begin
                        n_mt = b; n_ph = PH_MLEN; n_acc = '0; n_vb = '0;
                    end
                    PH_MLEN: begin
                        n_acc = acc_nx;
                        if (vlq_end) begin
                            emit_mh = 1'b1; ml = acc_nx;
                            mf = {4'd0, acc_nx} <= n_left;
                            n_skip = acc_nx;
                            if (!mf) n_ph = PH_SKIP;
                            else if (acc_nx != 28'd0) n_ph = PH_MDATA;
                            else if (mt0 == 8'h2F) n_ph = PH_DONE;
                            else begin n_ph = PH_DELTA; n_acc = '0; n_vb = '0; end
                        end else n_vb = vb0 + 2'd1;
                    end
                    PH_MDATA: begin
                        cnt = 2'd1; res[0].kind = K_MDATA; res[0].data1 = b;
                        res[0].meta_type = mt0;
                        n_skip = skip0 - 28'd1;
                        if (n_skip == 28'd0) begin
                            if (mt0 == 8'h2F) n_ph = PH_DONE;
                            else begin n_ph = PH_DELTA; n_acc = '0; n_vb = '0; end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = skip0 - 28'd1;
                        if (n_skip == 28'd0) begin
                            n_ph = PH_DELTA; n_acc = '0; n_vb = '0;
                        end
                    end
                    PH_SXLEN: begin
                        n_acc = acc_nx;
                        if (vlq_end) begin
                            n_skip = acc_nx;
                            if (acc_nx == 28'd0) begin
                                n_ph = PH_DELTA; n_acc = '0; n_vb = '0;
                            end else n_ph = PH_SKIP;
                        end else n_vb = vb0 + 2'd1;
                    end
                    default: ;
                endcase
                // chunk runs out: flush partial event, then done
                if (n_left == 32'd0 && n_ph != PH_DONE) begin
                    if (n_ph == PH_CH1 || n_ph == PH_CH2) emit_ch = 1'b1;
                    else if (n_ph == PH_MLEN) begin
                        emit_mh = 1'b1; ml = n_acc; mf = n_acc == 28'd0;
                    end
                    n_ph = PH_DONE;
                end
            end
        endcase
        tick_o = 40'(n_tick);
        if (emit_ch) begin
            dc = n_hc;
            d1 = (n_hc >= 2'd1) ? n_d1 : 8'd0;
            d2 = (n_hc >= 2'd2) ? b : 8'd0;
            res[0] = '0; res[0].kind = K_CHAN; res[0].abs_tick = tick_o;
            res[0].msg_type = n_rs[7:4]; res[0].channel = n_rs[3:0];
            res[0].data1 = d1; res[0].data2 = d2; res[0].data_count = dc;
            cnt = 2'd1;
        end
        if (emit_mh) begin
            mty = n_mt;
            res[0] = '0; res[0].kind = K_META; res[0].abs_tick = tick_o;
            res[0].meta_type = mty; res[0].meta_len = ml; res[0].meta_fits = mf;
            cnt = 2'd1;
        end
        if (cnt == 2'd1 && res[0].kind == K_MDATA) res[0].abs_tick = tick_o;
        if (n_ph == PH_DONE && ph0 != PH_DONE) begin
            res[cnt[0]] = '0; res[cnt[0]].kind = K_DONE;
            res[cnt[0]].abs_tick = tick_o;
            cnt = cnt + 2'd1;
        end
        if (cnt == 2'd2) res[1].last = 1'b1;
        else res[0].last = 1'b1;
        k = res[0].kind;
        if (k == K_ERR) res[0].abs_tick = tick_n40 & 40'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_TAG; r_tag <= '0; r_left <= '0; r_tick <= '0; r_acc <= '0;
            r_vb <= '0; r_rs <= '0; r_d1 <= '0; r_hc <= '0; r_mt <= '0; r_skip <= '0;
            o_pvalid <= 1'b0;
        end else begin
            if (acc) begin
                r_ph <= n_ph; r_tag <= n_tag; r_left <= n_left; r_tick <= n_tick;
                r_acc <= n_acc; r_vb <= n_vb; r_rs <= n_rs; r_d1 <= n_d1;
                r_hc <= n_hc; r_mt <= n_mt; r_skip <= n_skip;
                o_pvalid <= cnt != 2'd0;
            end else if (!i_pstall) o_pvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            o_pair.r0  <= res[0];
            o_pair.r1  <= res[1];
            o_pair.two <= cnt == 2'd2;
        end
    end

endmodule

FILE: rtl/core/mtcp_back.sv
// Back part: two-entry queue of result pairs, serializes each pair to the output.
// Depends on mtcp_pkg.
module mtcp_back import mtcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pvalid,
    input  t_pair i_pair,
    output logic  o_pstall,
    output logic  o_valid,
    output t_out  o_res,
    input  logic  i_stall
);

    t_pair      r_q [2];
    logic       r_wp, r_rp, r_sub;
    logic [1:0] r_cnt;
    logic       push, pop, take;

    assign o_pstall = r_cnt == 2'd2;
    assign push     = i_pvalid & ~o_pstall;
    assign o_valid  = r_cnt != 2'd0;
    assign o_res    = r_sub ? r_q[r_rp].r1 : r_q[r_rp].r0;
    assign take     = o_valid & ~i_stall;
    assign pop      = take & (r_sub | ~r_q[r_rp].two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_sub <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) begin
                r_rp <= ~r_rp; r_sub <= 1'b0;
            end else if (take) r_sub <= 1'b1;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_pair;
    end

endmodule

FILE: tb/tb.sv
// Testbench for midi_track_chunk_parser: random and directed MTrk byte streams,
// a behavioral predictor of the parser, and a scoreboard class. Depends on mtcp_pkg.
`timescale 1ns / 100ps

module tb;
    import mtcp_pkg::*;

    typedef enum int {
        P_TAG, P_LEN, P_DELTA, P_STATUS, P_MTYPE, P_MLEN, P_MDATA, P_SKIP, P_SXLEN,
        P_CH1, P_CH2, P_DONE, P_ERR
    } t_phase;

    // Behavioral model of the parser; produces expected results per request.
    class track_scoreboard;
        t_out        pending[$];
        int          n_errors;
        int          n_checked;
        t_phase      ph;
        int unsigned tag_idx;
        bit [31:0]   left;
        bit [39:0]   tick;
        bit [27:0]   vacc;
        int unsigned vcnt;
        bit [7:0]    rstat;
        bit [7:0]    hd1;
        int unsigned hcnt;
        bit [7:0]    hmt;
        bit [27:0]   skip;
        t_out        burst[$];

        function void clear();
            ph = P_TAG; tag_idx = 0; left = 0; tick = 0; vacc = 0; vcnt = 0;
            rstat = 0; hd1 = 0; hcnt = 0; hmt = 0; skip = 0;
        endfunction

        function void emit(t_kind k, bit [3:0] mt, bit [3:0] ch, bit [7:0] d1,
                           bit [7:0] d2, bit [1:0] cnt, bit [7:0] mty,
                           bit [27:0] ml, bit fit);
            t_out r;
            r.kind = k; r.abs_tick = (k == K_ERR) ? '0 : tick; r.msg_type = mt;
            r.channel = ch; r.data1 = d1; r.data2 = d2; r.data_count = cnt;
            r.meta_type = mty; r.meta_len = ml; r.meta_fits = fit; r.last = 0;
            burst = {burst, r};
        endfunction

        function void emit_chan(bit [7:0] d2);
            emit(K_CHAN, rstat[7:4], rstat[3:0], hcnt >= 1 ? hd1 : 8'd0,
                 hcnt >= 2 ? d2 : 8'd0, hcnt[1:0], 0, 0, 0);
        endfunction

        function void emit_done();
            ph = P_DONE;
            emit(K_DONE, 0, 0, 0, 0, 0, 0, 0, 0);
        endfunction

        function void to_delta();
            ph = P_DELTA; vacc = 0; vcnt = 0;
        endfunction

        function bit vlq_step(bit [7:0] b);
            vacc = {vacc[20:0], b[6:0]};
            if (!b[7] || vcnt + 1 >= 4) return 1;
            vcnt++;
            return 0;
        endfunction

        function bit single_data();
            return rstat[7:4] == 4'hC || rstat[7:4] == 4'hD;
        endfunction

        function void take_data1(bit [7:0] b);
            hd1 = b; hcnt = 1;
            if (single_data()) begin
                emit_chan(0);
                to_delta();
            end else begin
                ph = P_CH2;
            end
        endfunction

        function void body_byte(bit [7:0] b);
            bit fit;
            left--;
            case (ph)
                P_DELTA: if (vlq_step(b)) begin
                    tick += 40'(vacc);
                    ph = P_STATUS;
                end
                P_STATUS: begin
                    if (b == 8'hFF) begin
                        ph = P_MTYPE;
                    end else if (b == 8'hF0 || b == 8'hF7) begin
                        ph = P_SXLEN; vacc = 0; vcnt = 0;
                    end else if (b[7]) begin
                        rstat = b; hcnt = 0; hd1 = 0; ph = P_CH1;
                    end else if (rstat == 0) begin
                        to_delta();
                    end else begin
                        take_data1(b);
                    end
                end
                P_CH1: take_data1(b);
                P_CH2: begin
                    hcnt = 2;
                    emit_chan(b);
                    to_delta();
                end
                P_MTYPE: begin
                    hmt = b; ph = P_MLEN; vacc = 0; vcnt = 0;
                end
                P_MLEN: if (vlq_step(b)) begin
                    fit = {4'b0, vacc} <= left;
                    emit(K_META, 0, 0, 0, 0, 0, hmt, vacc, fit);
                    skip = vacc;
                    if (!fit) ph = P_SKIP;
                    else if (vacc != 0) ph = P_MDATA;
                    else if (hmt == 8'h2F) emit_done();
                    else to_delta();
                end
                P_MDATA: begin
                    emit(K_MDATA, 0, 0, b, 0, 0, hmt, 0, 0);
                    skip--;
                    if (skip == 0) begin
                        if (hmt == 8'h2F) emit_done();
                        else to_delta();
                    end
                end
                P_SKIP: begin
                    skip--;
                    if (skip == 0) to_delta();
                end
                P_SXLEN: if (vlq_step(b)) begin
                    skip = vacc;
                    if (skip == 0) to_delta();
                    else ph = P_SKIP;
                end
                default: ;
            endcase
            if (left == 0 && ph != P_DONE) begin
                if (ph == P_CH1 || ph == P_CH2) emit_chan(0);
                else if (ph == P_MLEN) emit(K_META, 0, 0, 0, 0, 0, hmt, vacc, vacc == 0);
                emit_done();
            end
        endfunction

        // Note one accepted request and queue its expected results.
        function void note_request(t_in req);
            bit [7:0] tag_ch[4];
            tag_ch = '{8'h4D, 8'h54, 8'h72, 8'h6B};
            burst.delete();
            if (req.start_track) clear();
            case (ph)
                P_TAG: begin
                    if (req.data_byte != tag_ch[tag_idx]) begin
                        ph = P_ERR;
                        emit(K_ERR, 0, 0, 0, 0, 0, 0, 0, 0);
                    end else if (tag_idx == 3) begin
                        tag_idx = 0; ph = P_LEN;
                    end else begin
                        tag_idx++;
                    end
                end
                P_LEN: begin
                    left = {left[23:0], req.data_byte};
                    if (tag_idx == 3) begin
                        tag_idx = 0;
                        if (left == 0) emit_done();
                        else to_delta();
                    end else begin
                        tag_idx++;
                    end
                end
                P_DONE, P_ERR: ;
                default: body_byte(req.data_byte);
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].last = 1;
            foreach (burst[i]) pending = {pending, burst[i]};
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $error("unexpected result kind %0d", got.kind);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.kind != e.kind) begin
                $error("kind exp %0d got %0d", e.kind, got.kind); n_errors++;
            end
            if (got.abs_tick != e.abs_tick) begin
                $error("abs_tick exp %0h got %0h", e.abs_tick, got.abs_tick); n_errors++;
            end
            if (got.msg_type != e.msg_type) begin
                $error("msg_type exp %0h got %0h", e.msg_type, got.msg_type); n_errors++;
            end
            if (got.channel != e.channel) begin
                $error("channel exp %0h got %0h", e.channel, got.channel); n_errors++;
            end
            if (got.data1 != e.data1) begin
                $error("data1 exp %0h got %0h", e.data1, got.data1); n_errors++;
            end
            if (got.data2 != e.data2) begin
                $error("data2 exp %0h got %0h", e.data2, got.data2); n_errors++;
            end
            if (got.data_count != e.data_count) begin
                $error("data_count exp %0d got %0d", e.data_count, got.data_count);
                n_errors++;
            end
            if (got.meta_type != e.meta_type) begin
                $error("meta_type exp %0h got %0h", e.meta_type, got.meta_type); n_errors++;
            end
            if (got.meta_len != e.meta_len) begin
                $error("meta_len exp %0h got %0h", e.meta_len, got.meta_len); n_errors++;
            end
            if (got.meta_fits != e.meta_fits) begin
                $error("meta_fits exp %0b got %0b", e.meta_fits, got.meta_fits); n_errors++;
            end
            if (got.last != e.last) begin
                $error("last exp %0b got %0b", e.last, got.last); n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    t_in  i_data = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall = 1;

    track_scoreboard sb = new();
    bit   in_quiet = 0;     // no idling on either side
    bit   long_hold = 0;
    int   idle_cycles = 0;
    int   n_sent = 0;
    bit   [7:0] track_bytes[$];

    always #2 i_clk = ~i_clk;

    midi_track_chunk_parser u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_request(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("midi_track_chunk_parser test failed");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1;
                for (k = 0; k < 60; k++) @(negedge i_clk);
                long_hold = 0;
                i_stall <= 0;
            end else if (!in_quiet && $urandom_range(0, 9) == 0) begin
                i_stall <= 1;
                for (k = $urandom_range(1, 5); k > 1; k--) @(negedge i_clk);
            end else begin
                i_stall <= 0;
            end
        end
    end

    task automatic send_byte(bit [7:0] b, bit st);
        int g;
        if (!in_quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            for (g = $urandom_range(1, 5); g > 0; g--) @(negedge i_clk);
        end
        i_valid <= 1;
        i_data <= '{data_byte: b, start_track: st};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_track();
        foreach (track_bytes[i]) send_byte(track_bytes[i], i == 0);
        i_valid <= 0;
    endtask

    task automatic wait_drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic void put_vlq(bit [27:0] v, int nb);
        for (int i = nb - 1; i >= 0; i--)
            track_bytes = {track_bytes, {i != 0, 7'(v >> (7 * i))}};
    endfunction

    function automatic void begin_track();
        track_bytes = '{8'h4D, 8'h54, 8'h72, 8'h6B, 0, 0, 0, 0};
    endfunction

    // Patch the four-byte length field.
    function automatic void set_len(bit [31:0] len);
        {track_bytes[4], track_bytes[5], track_bytes[6], track_bytes[7]} = len;
    endfunction

    // Random event sequence; mostly well formed.
    function automatic void add_events(int n_ev);
        int kind_sel, len;
        bit [7:0] st;
        for (int e = 0; e < n_ev; e++) begin
            if ($urandom_range(0, 3) == 0) put_vlq(28'($urandom), $urandom_range(1, 5));
            else put_vlq($urandom_range(0, 300), $urandom_range(0, 1) ? 2 : 1);
            kind_sel = $urandom_range(0, 19);
            if (kind_sel < 12) begin
                if (kind_sel >= 3) begin
                    st = {1'b1, 3'($urandom), 4'($urandom)};
                    if (kind_sel == 11) st = 8'($urandom_range(8'hF1, 8'hFE));
                    if (st == 8'hF7 || st == 8'hFF) st = 8'h90;
                    track_bytes = {track_bytes, st};
                end
                track_bytes = {track_bytes, 8'($urandom_range(0, 127))};
                track_bytes = {track_bytes, 8'($urandom_range(0, 127))};
            end else if (kind_sel < 17) begin
                len = $urandom_range(0, 6);
                track_bytes = {track_bytes, 8'hFF};
                track_bytes = {track_bytes, 8'($urandom)};
                put_vlq(28'(len), 1);
                for (int j = 0; j < len; j++) track_bytes = {track_bytes, 8'($urandom)};
            end else if (kind_sel < 19) begin
                len = $urandom_range(0, 4);
                track_bytes = {track_bytes, ($urandom_range(0, 1) ? 8'hF0 : 8'hF7)};
                put_vlq(28'(len), 1);
                for (int j = 0; j < len; j++) track_bytes = {track_bytes, 8'($urandom)};
            end else begin
                track_bytes = {track_bytes, 8'($urandom)};
            end
        end
    endfunction

    function automatic void build_random_track();
        int body, mode;
        begin_track();
        add_events($urandom_range(1, 12));
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            track_bytes = {track_bytes, 8'h00, 8'hFF, 8'h2F, 8'h00};
        end
        body = track_bytes.size() - 8;
        if (mode == 6 && body > 1) body = $urandom_range(1, body);
        else if (mode == 7) body = body + $urandom_range(1, 8);
        else if (mode == 8) body = int'($urandom >> 1);
        set_len(body);
        if (track_bytes.size() > 8 + body) track_bytes = track_bytes[0:7 + body];
        if (mode == 9) track_bytes[$urandom_range(0, 3)] = 8'($urandom);
        if (mode == 8) track_bytes = {track_bytes, 8'($urandom)};
    endfunction

    initial begin
        int n_tracks;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        sb.clear();

        // Bytes before any start flag: good tag then zero length.
        track_bytes = '{8'h4D, 8'h54, 8'h72, 8'h6B, 0, 0, 0, 0};
        foreach (track_bytes[i]) send_byte(track_bytes[i], 0);
        send_byte(8'h00, 0);  // ignored after done
        // Tag broken at its second byte, then ignored bytes.
        send_byte(8'h4D, 1); send_byte(8'h00, 0); send_byte(8'hFF, 0);
        // Directed chunk: overlong VLQ, orphan data, F3, meta EOT.
        begin_track();
        track_bytes = {track_bytes, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05, 8'h7F};
        track_bytes = {track_bytes, 8'h00, 8'hC5, 8'h7F, 8'h00, 8'h00, 8'hF3, 8'h01,
                       8'h02, 8'h00, 8'hFF, 8'h2F, 8'h00};
        set_len(track_bytes.size() - 8);
        send_track();
        // Length running out inside a meta length.
        begin_track();
        track_bytes = {track_bytes, 8'h00, 8'hFF, 8'h01, 8'h81};
        set_len(4);
        send_track();
        wait_drain();

        // Long receiver hold-off while the sender keeps offering result-heavy bytes.
        long_hold = 1;
        begin_track();
        for (int j = 0; j < 16; j++) track_bytes = {track_bytes, 8'h00, 8'hC1, 8'(j)};
        track_bytes = {track_bytes, 8'h00, 8'hFF, 8'h2F, 8'h00};
        set_len(track_bytes.size() - 8);
        send_track();
        wait_drain();

        n_tracks = 0;
        while (n_sent < 1750) begin
            if (n_sent > 1450) in_quiet = 1;
            build_random_track();
            send_track();
            n_tracks++;
            if (n_tracks % 40 == 0) wait_drain();
        end
        wait_drain();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d bytes in %0d random tracks; %0d results checked.",
                 n_sent, n_tracks, sb.n_checked);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("midi_track_chunk_parser test passed");
        else
            $display("midi_track_chunk_parser test failed");
        $finish;
    end
endmodule

FILE: midi_track_chunk_parser.f
rtl/core/mtcp_pkg.sv
rtl/core/mtcp_front.sv
rtl/core/mtcp_back.sv
rtl/core/midi_track_chunk_parser.sv
tb/tb.sv
